/* design/rx_duplicate_frame_filter_macros.svh */
// Assertion macros for the received-frame duplicate filter.
// Used by the checker module; relies on signals named clk and rst_n in scope.
`ifndef RX_DUPLICATE_FRAME_FILTER_MACROS_SVH
`define RX_DUPLICATE_FRAME_FILTER_MACROS_SVH

// Property checked at every clock edge outside reset.
`define RDFF_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("rdff assertion failed");

// Property checked at every clock edge, reset included.
`define RDFF_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("rdff assertion failed");

`endif

/* design/rdff_pkg.sv */
// Shared types and constants for the received-frame duplicate filter.
// No dependencies; used by every module of the block but rdff_ram.
`timescale 1ns / 1ps

package rdff_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int FILL_W = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_W = 48;
  localparam int SEQ_W  = 16;

  localparam int IN_TDATA_W  = ADDR_W + SEQ_W;
  localparam int OUT_TDATA_W = 24;

  localparam int OUT_IS_NEW_BIT  = 0;
  localparam int OUT_KNOWN_BIT   = 1;
  localparam int OUT_SEQ_LSB     = 2;
  localparam int OUT_FULL_BIT    = OUT_SEQ_LSB + SEQ_W;

  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_WRAP_LOW_WINDOW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WRAP_HIGH_MARK  = 8'd1;

  localparam logic [SEQ_W-1:0] WRAP_LOW_WINDOW_RESET = 16'd100;
  localparam logic [SEQ_W-1:0] WRAP_HIGH_MARK_RESET  = 16'd65435;

  localparam logic CMD_CHECK_RECORD = 1'b0;
  localparam logic CMD_CHECK_ONLY   = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_DECIDE
  } rdff_state_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] fill_idx;
    logic             full;
  } rdff_lookup_t;

endpackage

/* design/rx_duplicate_frame_filter.sv */
// Top level of the received-frame duplicate filter.
// Depends on rdff_pkg, rdff_cam and rdff_ram.
`timescale 1ns / 1ps

// Usage.
// Each received frame enters as one transaction on the in_ channel: in_tdata holds the
// source address and sequence number, in_tuser the command (check and record, or check
// only). One result transaction per frame leaves on the out_ channel with the new-frame
// verdict, whether the source was known, the previously stored sequence number and a
// table-full flag.
// In the accept cycle the address is matched against all table entries in parallel
// and the stored sequence RAM is read; in the decide state that follows, once the
// output register is free, the verdict is formed and the RAM and address table are
// written back. The block takes no new frame until the previous one has left the
// decide state, and the result is registered in the output register as it leaves.
// The registered read of the sequence RAM is why the verdict waits for that state.
// The wrap thresholds are written through the cfg_ channel, which is always ready;
// writes to unknown indices are ignored.
// Reset empties the table and restores the default wrap thresholds; no clearing pass
// is needed. While the receiver stalls, the result is held in the output register and
// the block takes no further frame once that register is needed again.

module rx_duplicate_frame_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [47:0] source_address, [63:48] seq_num
  input  logic [rdff_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [0] cmd
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [0] is_new, [1] source_known, [17:2] stored_seq, [18] table_full, [23:19] zero
  output logic [rdff_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rdff_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rdff_pkg::SEQ_W-1:0]         cfg_data
);

  rdff_pkg::rdff_state_t state_r, state_nxt;

  logic [rdff_pkg::SEQ_W-1:0]  wrap_low_r, wrap_high_r;
  logic                        cmd_r;
  logic [rdff_pkg::ADDR_W-1:0] addr_r;
  logic [rdff_pkg::SEQ_W-1:0]  seq_r;
  rdff_pkg::rdff_lookup_t      lookup;
  rdff_pkg::rdff_lookup_t      lk_r;

  logic                        in_accept;
  logic                        decide_go;
  logic [rdff_pkg::SEQ_W-1:0]  last_seq;
  logic                        advance;
  logic                        is_new;
  logic                        table_full;
  logic                        record;
  logic                        ram_we;
  logic [rdff_pkg::IDX_W-1:0]  ram_waddr;
  logic [rdff_pkg::IDX_W-1:0]  ram_raddr;
  logic                        cam_ins;

  logic                             out_valid_r, out_valid_nxt;
  logic [rdff_pkg::OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_low_r  <= rdff_pkg::WRAP_LOW_WINDOW_RESET;
      wrap_high_r <= rdff_pkg::WRAP_HIGH_MARK_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == rdff_pkg::REG_WRAP_LOW_WINDOW) begin
        wrap_low_r <= cfg_data;
      end
      if (cfg_index == rdff_pkg::REG_WRAP_HIGH_MARK) begin
        wrap_high_r <= cfg_data;
      end
    end
  end

  rdff_cam u_cam (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_addr (in_tdata[rdff_pkg::ADDR_W-1:0]),
    .lookup      (lookup),
    .ins_en      (cam_ins),
    .ins_addr    (addr_r)
  );

  assign ram_raddr = (state_r == rdff_pkg::ST_IDLE) ? lookup.hit_idx : lk_r.hit_idx;

  rdff_ram #(
    .WIDTH (rdff_pkg::SEQ_W),
    .DEPTH (rdff_pkg::TABLE_ENTRIES)
  ) u_seq_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (seq_r),
    .raddr (ram_raddr),
    .rdata (last_seq)
  );

  assign in_tready = (state_r == rdff_pkg::ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign decide_go = (state_r == rdff_pkg::ST_DECIDE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rdff_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = rdff_pkg::ST_DECIDE;
        end
      end
      rdff_pkg::ST_DECIDE: begin
        if (decide_go) begin
          state_nxt = rdff_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rdff_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rdff_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_r  <= in_tuser;
      addr_r <= in_tdata[rdff_pkg::ADDR_W-1:0];
      seq_r  <= in_tdata[rdff_pkg::IN_TDATA_W-1:rdff_pkg::ADDR_W];
      lk_r   <= lookup;
    end
  end

  assign advance    = ((seq_r < wrap_low_r) && (last_seq >= wrap_high_r)) || (seq_r > last_seq);
  assign is_new     = !lk_r.hit || advance;
  assign record     = decide_go && (cmd_r == rdff_pkg::CMD_CHECK_RECORD);
  assign table_full = !lk_r.hit && lk_r.full && (cmd_r == rdff_pkg::CMD_CHECK_RECORD);
  assign cam_ins    = record && !lk_r.hit && !lk_r.full;
  assign ram_we     = (record && lk_r.hit && advance) || cam_ins;
  assign ram_waddr  = lk_r.hit ? lk_r.hit_idx : lk_r.fill_idx;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (decide_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    out_data_nxt = '0;
    out_data_nxt[rdff_pkg::OUT_IS_NEW_BIT] = is_new;
    out_data_nxt[rdff_pkg::OUT_KNOWN_BIT]  = lk_r.hit;
    out_data_nxt[rdff_pkg::OUT_SEQ_LSB +: rdff_pkg::SEQ_W] = lk_r.hit ? last_seq : '0;
    out_data_nxt[rdff_pkg::OUT_FULL_BIT]   = table_full;
  end

  always_ff @(posedge clk) begin
    if (decide_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

/* design/rdff_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module rdff_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/rdff_cam.sv */
// Source address table: parallel match over the filled entries and in-order insertion.
// Depends on rdff_pkg.
`timescale 1ns / 1ps

module rdff_cam (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [rdff_pkg::ADDR_W-1:0]   lookup_addr,
  output rdff_pkg::rdff_lookup_t        lookup,
  input  logic                          ins_en,
  input  logic [rdff_pkg::ADDR_W-1:0]   ins_addr
);

  logic [rdff_pkg::ADDR_W-1:0] addr_r [rdff_pkg::TABLE_ENTRIES];
  logic [rdff_pkg::FILL_W-1:0] fill_r;
  logic [rdff_pkg::FILL_W-1:0] fill_nxt;

  always_comb begin
    lookup.hit      = 1'b0;
    lookup.hit_idx  = '0;
    lookup.fill_idx = fill_r[rdff_pkg::IDX_W-1:0];
    lookup.full     = (fill_r == rdff_pkg::FILL_W'(rdff_pkg::TABLE_ENTRIES));
    for (int i = rdff_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
      if ((rdff_pkg::FILL_W'(i) < fill_r) && (addr_r[i] == lookup_addr)) begin
        lookup.hit     = 1'b1;
        lookup.hit_idx = rdff_pkg::IDX_W'(i);
      end
    end
  end

  assign fill_nxt = ins_en ? fill_r + rdff_pkg::FILL_W'(1) : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < rdff_pkg::TABLE_ENTRIES; i++) begin
      if (ins_en && (fill_r == rdff_pkg::FILL_W'(i))) begin
        addr_r[i] <= ins_addr;
      end
    end
  end

endmodule

/* design/rdff_checker.sv */
// Port-level checker for the received-frame duplicate filter, bound to the top level.
// Depends on rdff_pkg and rx_duplicate_frame_filter_macros.svh.
`timescale 1ns / 1ps
`include "rx_duplicate_frame_filter_macros.svh"

module rdff_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [rdff_pkg::OUT_TDATA_W-1:0] out_tdata
);

  logic                       res_new;
  logic                       res_known;
  logic                       res_full;
  logic [rdff_pkg::SEQ_W-1:0] res_stored;

  assign res_new    = out_tdata[rdff_pkg::OUT_IS_NEW_BIT];
  assign res_known  = out_tdata[rdff_pkg::OUT_KNOWN_BIT];
  assign res_full   = out_tdata[rdff_pkg::OUT_FULL_BIT];
  assign res_stored = out_tdata[rdff_pkg::OUT_SEQ_LSB +: rdff_pkg::SEQ_W];

  `RDFF_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `RDFF_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid)
  `RDFF_ASSERT(a_one_in_flight, in_tvalid && in_tready |=> !in_tready)
  `RDFF_ASSERT(a_full_unknown, out_tvalid && res_full |-> res_new && !res_known)
  `RDFF_ASSERT(a_unknown_zero, out_tvalid && !res_known |-> res_new && (res_stored == '0))

endmodule

bind rx_duplicate_frame_filter rdff_checker u_rdff_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for rx_duplicate_frame_filter, built on rdff_pkg.
// Frames are driven with random pacing, wrap-threshold writes between runs;
// each verdict is predicted by a table model of its own, checked in order.

module tb;
  import rdff_pkg::*;

  typedef struct {
    logic             is_new;
    logic             known;
    logic [SEQ_W-1:0] stored;
    logic             full;
  } verdict_t;

  logic                   clk;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tuser = CMD_CHECK_RECORD;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [SEQ_W-1:0]       cfg_data = '0;

  logic [ADDR_W-1:0] src_addr [TABLE_ENTRIES];
  logic [SEQ_W-1:0]  src_last_seq [TABLE_ENTRIES];
  int                src_count = 0;
  logic [SEQ_W-1:0]  low_window = WRAP_LOW_WINDOW_RESET;
  logic [SEQ_W-1:0]  high_mark = WRAP_HIGH_MARK_RESET;
  verdict_t          pending_verdicts [$];
  int                errors = 0;
  int                in_idle_pct = 0;
  int                out_stall_pct = 0;
  int                stall_left = 0;

  rx_duplicate_frame_filter DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic verdict_t judge_frame(logic cmd, logic [ADDR_W-1:0] addr,
                                           logic [SEQ_W-1:0] seq);
    verdict_t v;
    int       hit;
    v = '{is_new: 1'b0, known: 1'b0, stored: '0, full: 1'b0};
    hit = -1;
    for (int i = src_count - 1; i >= 0; i--) begin
      if (src_addr[i] == addr) hit = i;
    end
    if (hit >= 0) begin
      v.known = 1'b1;
      v.stored = src_last_seq[hit];
      if (seq > src_last_seq[hit] ||
          (seq < low_window && src_last_seq[hit] >= high_mark)) begin
        v.is_new = 1'b1;
        if (cmd == CMD_CHECK_RECORD) src_last_seq[hit] = seq;
      end
    end else begin
      v.is_new = 1'b1;
      if (cmd == CMD_CHECK_RECORD) begin
        if (src_count < TABLE_ENTRIES) begin
          src_addr[src_count] = addr;
          src_last_seq[src_count] = seq;
          src_count++;
        end else begin
          v.full = 1'b1;
        end
      end
    end
    return v;
  endfunction

  function automatic logic [SEQ_W-1:0] pick_seq(logic [SEQ_W-1:0] last);
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return SEQ_W'(last + $urandom_range(1, 8));
    if (r < 65) return SEQ_W'(last - $urandom_range(0, 8));
    if (r < 75) return SEQ_W'(high_mark + $urandom_range(0, 2) - 1);
    if (r < 85) return SEQ_W'(low_window + $urandom_range(0, 2) - 1);
    return SEQ_W'($urandom);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      stall_left <= pick_gap(out_stall_pct);
    end
  end

  task automatic check_field(string name, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    verdict_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result with no frame outstanding, expected none, actual %h",
                 $time, out_tdata);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        check_field("is_new", SEQ_W'(want.is_new), SEQ_W'(out_tdata[OUT_IS_NEW_BIT]));
        check_field("source_known", SEQ_W'(want.known), SEQ_W'(out_tdata[OUT_KNOWN_BIT]));
        check_field("stored_seq", want.stored, out_tdata[OUT_SEQ_LSB +: SEQ_W]);
        check_field("table_full", SEQ_W'(want.full), SEQ_W'(out_tdata[OUT_FULL_BIT]));
        check_field("padding", '0, SEQ_W'(out_tdata[OUT_TDATA_W-1:OUT_FULL_BIT+1]));
      end
    end
  end

  task automatic send_frame(logic cmd, logic [ADDR_W-1:0] addr, logic [SEQ_W-1:0] seq);
    int gap;
    gap = pick_gap(in_idle_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata <= {$urandom, $urandom};
      in_tuser <= 1'($urandom_range(0, 1));
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {seq, addr};
    in_tuser <= cmd;
    do @(posedge clk); while (!in_tready);
    pending_verdicts.push_back(judge_frame(cmd, addr, seq));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [SEQ_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_WRAP_LOW_WINDOW) low_window = value;
    else if (idx == REG_WRAP_HIGH_MARK) high_mark = value;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random_frames(int count);
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [SEQ_W-1:0]  seq;
    int                slot;
    for (int k = 0; k < count; k++) begin
      cmd = ($urandom_range(0, 4) == 0) ? CMD_CHECK_ONLY : CMD_CHECK_RECORD;
      if (src_count == 0 || $urandom_range(0, 9) == 0) begin
        addr = ADDR_W'({$urandom, $urandom});
        seq = SEQ_W'($urandom);
      end else begin
        slot = $urandom_range(0, src_count - 1);
        addr = src_addr[slot];
        seq = pick_seq(src_last_seq[slot]);
      end
      send_frame(cmd, addr, seq);
    end
  endtask

  task automatic test_first_contact();
    in_idle_pct = 20;
    out_stall_pct = 20;
    send_frame(CMD_CHECK_ONLY, '0, '0);
    send_frame(CMD_CHECK_RECORD, '0, '0);
    send_frame(CMD_CHECK_RECORD, '0, '0);
    send_frame(CMD_CHECK_RECORD, '1, '1);
    send_frame(CMD_CHECK_ONLY, '1, '0);
    send_frame(CMD_CHECK_RECORD, '1, '0);
    send_frame(CMD_CHECK_ONLY, '0, 16'd1);
    send_frame(CMD_CHECK_RECORD, '0, 16'd1);
    send_frame(CMD_CHECK_RECORD, '0, '0);
    send_frame(CMD_CHECK_ONLY, '0, 16'd1);
  endtask

  task automatic test_table_fill();
    logic [ADDR_W-1:0] addr;
    while (src_count < TABLE_ENTRIES) begin
      addr = ADDR_W'(1) << (src_count * 3 + 1);
      send_frame(CMD_CHECK_RECORD, addr, SEQ_W'($urandom));
    end
    send_frame(CMD_CHECK_RECORD, 48'h5a5a_a5a5_0f0f, '1);
    send_frame(CMD_CHECK_ONLY, 48'h5a5a_a5a5_0f0f, '1);
    send_frame(CMD_CHECK_RECORD, 48'ha5a5_5a5a_f0f0, '0);
  endtask

  task automatic test_wrap_thresholds(logic [SEQ_W-1:0] low, logic [SEQ_W-1:0] high,
                                      int count, int in_pct, int out_pct);
    drain_results();
    write_reg(REG_WRAP_LOW_WINDOW, low);
    write_reg(REG_WRAP_HIGH_MARK, high);
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
    run_random_frames(count);
  endtask

  task automatic test_unused_registers();
    drain_results();
    write_reg(CFG_IDX_W'(REG_WRAP_HIGH_MARK + 1), SEQ_W'($urandom));
    write_reg({CFG_IDX_W{1'b1}}, SEQ_W'($urandom));
    in_idle_pct = 30;
    out_stall_pct = 30;
    run_random_frames(60);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_first_contact();
    test_table_fill();
    in_idle_pct = 30;
    out_stall_pct = 30;
    run_random_frames(180);
    test_wrap_thresholds('0, '0, 180, 0, 0);
    test_wrap_thresholds('1, '1, 170, 60, 10);
    test_wrap_thresholds('1, '0, 150, 10, 60);
    test_wrap_thresholds(SEQ_W'($urandom), SEQ_W'($urandom), 160, 30, 30);
    test_unused_registers();
    test_wrap_thresholds(16'd1000, 16'd60000, 150, 20, 20);
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0 && pending_verdicts.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/rdff_pkg.sv
design/rdff_ram.sv
design/rdff_cam.sv
design/rx_duplicate_frame_filter.sv
design/rdff_checker.sv
dv/tb.sv
